// File: design/sia_pkg.sv
// Package: operation codes, status codes and divider cell types for the integer ALU.
`timescale 1ns / 1ps
package sia_pkg;

  localparam int DataW  = 32;
  localparam int StageN = DataW;

  typedef enum logic [3:0] {
    OP_SET   = 4'd0,
    OP_SUB   = 4'd1,
    OP_ADD   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_MOD   = 4'd5,
    OP_AND   = 4'd6,
    OP_OR    = 4'd7,
    OP_XOR   = 4'd8,
    OP_SETB  = 4'd9,
    OP_CLRB  = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIV0  = 2'd1,
    ST_BADOP = 2'd2
  } status_t;

  // One word traveling down the divider chain, with the finished result beside it.
  typedef struct packed {
    logic              vld;
    logic              is_div;
    logic              neg_q;
    logic              neg_r;
    logic [DataW-1:0]  rem;
    logic [DataW-1:0]  quo;
    logic [DataW-1:0]  dvs;
    logic [DataW-1:0]  res;
    status_t           st;
  } cell_t;

endpackage

// File: design/sia_cell.sv
// One divider cell: a single restoring step on the word passing through.
`timescale 1ns / 1ps
module sia_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  sia_pkg::cell_t d_in,
  output sia_pkg::cell_t d_out
);
  import sia_pkg::*;

  cell_t             d_out_r;
  cell_t             d_out_nxt;
  logic [DataW:0]    trial;
  logic [DataW:0]    diff;

  always_comb begin
    d_out_nxt = d_in;
    trial     = {d_in.rem, d_in.quo[DataW-1]};
    diff      = trial - {1'b0, d_in.dvs};
    d_out_nxt.quo = {d_in.quo[DataW-2:0], ~diff[DataW]};
    d_out_nxt.rem = diff[DataW] ? trial[DataW-1:0] : diff[DataW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_out_r.vld <= 1'b0;
    end else begin
      d_out_r.vld <= d_in.vld;
    end
    d_out_r.is_div <= d_out_nxt.is_div;
    d_out_r.neg_q  <= d_out_nxt.neg_q;
    d_out_r.neg_r  <= d_out_nxt.neg_r;
    d_out_r.rem    <= d_out_nxt.rem;
    d_out_r.quo    <= d_out_nxt.quo;
    d_out_r.dvs    <= d_out_nxt.dvs;
    d_out_r.res    <= d_out_nxt.res;
    d_out_r.st     <= d_out_nxt.st;
  end

  assign d_out = d_out_r;
endmodule

// File: design/script_integer_alu.sv
// Top level: 32-bit integer ALU built around a chain of divider cells.
`timescale 1ns / 1ps
// out_valid rises once an accepted word has passed the head register, the divider chain and the output register.
// Throughput: one word per cycle; busy is never raised.
// The chain is the 32-cell restoring divider, which all words traverse.
// Reset (synchronous, rst_n low) clears the valid bits of the chain; words in flight drop.
// The receiver cannot stall: each result appears for exactly one cycle.
module script_integer_alu (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [3:0]                 in_action,
  input  logic signed [31:0]         in_operand_a,
  input  logic signed [31:0]         in_operand_b,
  output logic                       out_valid,
  output logic signed [31:0]         out_result_value,
  output logic [1:0]                 out_status
);
  import sia_pkg::*;

  cell_t             head_r;
  cell_t             head_nxt;
  cell_t             chain [StageN+1];
  logic [DataW-1:0]  a;
  logic [DataW-1:0]  b;
  logic [2*DataW-1:0] prod;
  logic              out_valid_r;
  logic [DataW-1:0]  out_value_r;
  logic [DataW-1:0]  out_value_nxt;
  status_t           out_status_r;
  cell_t             tail;

  assign busy = 1'b0;
  assign a    = in_operand_a;
  assign b    = in_operand_b;
  assign prod = a * b;

  // Decode and do the simple operations; set up the divider for div/mod.
  always_comb begin
    head_nxt        = '0;
    head_nxt.vld    = start;
    head_nxt.st     = ST_OK;
    head_nxt.dvs    = b[DataW-1] ? (~b + 1'b1) : b;
    head_nxt.quo    = a[DataW-1] ? (~a + 1'b1) : a;
    head_nxt.neg_q  = a[DataW-1] ^ b[DataW-1];
    head_nxt.neg_r  = a[DataW-1];
    case (in_action)
      OP_SET:  head_nxt.res = b;
      OP_SUB:  head_nxt.res = a - b;
      OP_ADD:  head_nxt.res = a + b;
      OP_MUL:  head_nxt.res = prod[DataW-1:0];
      OP_DIV, OP_MOD: begin
        head_nxt.is_div = (b != '0);
        if (b == '0) begin
          head_nxt.st = ST_DIV0;
        end
        head_nxt.res = (in_action == OP_DIV) ? '1 : '0;
      end
      OP_AND:  head_nxt.res = a & b;
      OP_OR:   head_nxt.res = a | b;
      OP_XOR:  head_nxt.res = a ^ b;
      OP_SETB: head_nxt.res = (b < DataW) ? (a | (DataW'(1) << b[4:0])) : a;
      OP_CLRB: head_nxt.res = (b < DataW) ? (a & ~(DataW'(1) << b[4:0])) : a;
      default: head_nxt.st  = ST_BADOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.vld <= 1'b0;
    end else begin
      head_r.vld <= head_nxt.vld;
    end
    head_r.is_div <= head_nxt.is_div;
    head_r.neg_q  <= head_nxt.neg_q;
    head_r.neg_r  <= head_nxt.neg_r;
    head_r.rem    <= head_nxt.rem;
    head_r.quo    <= head_nxt.quo;
    head_r.dvs    <= head_nxt.dvs;
    head_r.res    <= head_nxt.res;
    head_r.st     <= head_nxt.st;
  end

  assign chain[0] = head_r;

  genvar gi;
  generate
    for (gi = 0; gi < StageN; gi++) begin : g_cell
      sia_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .d_in  (chain[gi]),
        .d_out (chain[gi+1])
      );
    end
  endgenerate

  assign tail = chain[StageN];

  // Pick the divider answer (res holds all ones for div, zero for mod) and fix signs; zero on error status.
  always_comb begin
    out_value_nxt = tail.res;
    if (tail.is_div) begin
      if (tail.res[0]) begin
        out_value_nxt = tail.neg_q ? (~tail.quo + 1'b1) : tail.quo;
      end else begin
        out_value_nxt = tail.neg_r ? (~tail.rem + 1'b1) : tail.rem;
      end
    end else if (tail.st != ST_OK) begin
      out_value_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tail.vld;
    end
    out_value_r  <= out_value_nxt;
    out_status_r <= tail.st;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;

`ifndef SYNTHESIS
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    head_r.vld |-> ##(StageN+1) out_valid)
    else $error("result lost in chain");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_result_value == '0))
    else $error("error result not zero");
  a_no_st3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("bad status code");
`endif
endmodule

// File: verif/testbench.sv
// Testbench for the integer ALU: queued stimulus, result predictor and in-order checker.
`timescale 1ns / 1ps
module testbench;
  import sia_pkg::*;

  localparam int LatencyCyc = DataW + 2;
  localparam int IdleLimit  = 2000;

  typedef struct {
    logic [3:0]  action;
    logic [31:0] opa;
    logic [31:0] opb;
  } word_t;

  typedef struct {
    logic [31:0] value;
    status_t     status;
  } alu_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [3:0] in_action = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic out_valid;
  logic signed [31:0] out_result_value;
  logic [1:0] out_status;

  word_t    pending_q[$];
  alu_res_t expected_q[$];
  int       errors = 0;
  int       idle_cycles = 0;
  bit       stim_done = 1'b0;
  bit       no_gaps = 1'b0;
  logic     accepted = 1'b0;

  script_integer_alu u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_status       (out_status)
  );

  always #10 clk = ~clk;

  function automatic alu_res_t compute_alu(word_t w);
    alu_res_t r;
    logic [31:0] ma, mb, uq, ur;
    r.value  = '0;
    r.status = ST_OK;
    case (w.action)
      OP_SET: r.value = w.opb;
      OP_SUB: r.value = w.opa - w.opb;
      OP_ADD: r.value = w.opa + w.opb;
      OP_MUL: r.value = w.opa * w.opb;
      OP_DIV, OP_MOD: begin
        if (w.opb == 0) begin
          r.status = ST_DIV0;
        end else begin
          ma = w.opa[31] ? -w.opa : w.opa;
          mb = w.opb[31] ? -w.opb : w.opb;
          uq = ma / mb;
          ur = ma % mb;
          if (w.action == OP_DIV) r.value = (w.opa[31] != w.opb[31]) ? -uq : uq;
          else r.value = w.opa[31] ? -ur : ur;
        end
      end
      OP_AND: r.value = w.opa & w.opb;
      OP_OR:  r.value = w.opa | w.opb;
      OP_XOR: r.value = w.opa ^ w.opb;
      OP_SETB: r.value = (w.opb < 32) ? (w.opa | (32'd1 << w.opb[4:0])) : w.opa;
      OP_CLRB: r.value = (w.opb < 32) ? (w.opa & ~(32'd1 << w.opb[4:0])) : w.opa;
      default: r.status = ST_BADOP;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom_range(0, 40);
      5: return -$urandom_range(1, 40);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_word(logic [3:0] act, logic [31:0] a, logic [31:0] b);
    word_t w;
    w.action = act;
    w.opa = a;
    w.opb = b;
    pending_q.push_back(w);
  endtask

  // Driver: present words at the falling edge, hold until accepted.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!start || accepted) begin
        if (pending_q.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 30)) begin
          in_action    <= pending_q[0].action;
          in_operand_a <= pending_q[0].opa;
          in_operand_b <= pending_q[0].opb;
          start        <= 1'b1;
          pending_q.pop_front();
        end else begin
          start        <= 1'b0;
          in_action    <= 4'($urandom);
          in_operand_a <= $urandom;
          in_operand_b <= $urandom;
        end
      end
    end
  end

  // Monitor: capture accepted words and results at the rising edge.
  always @(posedge clk) begin
    word_t w;
    alu_res_t got, exp_r;
    accepted <= rst_n && start && !busy;
    if (rst_n) begin
      idle_cycles = idle_cycles + 1;
      if (start && !busy) begin
        w.action = in_action;
        w.opa = in_operand_a;
        w.opb = in_operand_b;
        expected_q.push_back(compute_alu(w));
        idle_cycles = 0;
      end
      if (out_valid) begin
        idle_cycles = 0;
        got.value = out_result_value;
        got.status = status_t'(out_status);
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result value=%h status=%0d", $time, got.value, out_status);
          errors = errors + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.value !== exp_r.value) begin
            $display("%0t: value mismatch expected=%h actual=%h", $time, exp_r.value, got.value);
            errors = errors + 1;
          end
          if (out_status !== exp_r.status) begin
            $display("%0t: status mismatch expected=%0d actual=%0d",
                     $time, exp_r.status, out_status);
            errors = errors + 1;
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] corner[6];
    int n;
    corner = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd0, 32'd1, 32'h5a5a_a5a5};
    // directed: every code, wrap cases, zero divisors, min over minus one, bit indexes
    for (int op = 0; op < 16; op++) add_word(op[3:0], corner[op % 6], corner[(op + 2) % 6]);
    add_word(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    add_word(OP_MOD, 32'h8000_0000, 32'hffff_ffff);
    add_word(OP_DIV, 32'hffff_fff9, 32'd2);
    add_word(OP_MOD, 32'hffff_fff9, 32'd2);
    add_word(OP_MOD, 32'd7, 32'hffff_fffe);
    add_word(OP_DIV, 32'd5, 32'd0);
    add_word(OP_SETB, 32'd0, 32'd31);
    add_word(OP_CLRB, 32'hffff_ffff, 32'd32);
    add_word(OP_SETB, 32'd0, 32'hffff_ffff);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 600; i++) begin
      n = $urandom_range(0, 15);
      if (n > 11) n = $urandom_range(0, 10);
      if (n >= OP_SETB && n <= OP_CLRB && $urandom_range(0, 3) != 0)
        add_word(n[3:0], pick_operand(), $urandom_range(0, 31));
      else
        add_word(n[3:0], pick_operand(), pick_operand());
      if (i == 200) begin
        no_gaps = 1'b1;
        wait (pending_q.size() == 0);
        no_gaps = 1'b0;
      end
    end
    wait (pending_q.size() == 0);
    // let the last presented word be taken and queued by the monitor
    repeat (2) @(posedge clk);
    wait (expected_q.size() == 0);
    repeat (LatencyCyc) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
